// ----- rtl/alpha_blend_pixel_store_core_assert.svh -----
// assertion macros used by the pixel store checker
`ifndef ALPHA_BLEND_PIXEL_STORE_CORE_ASSERT_SVH
`define ALPHA_BLEND_PIXEL_STORE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define ABPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ABPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/abps_pkg.sv -----
// types, constants and blend functions of the alpha blend pixel store
`timescale 1ns / 1ps

package abps_pkg;

    // default surface limits
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // configuration port
    localparam int CFG_W       = 9;
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]       SURFACE_RESET      = 9'd256;

    // request modes
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // alpha codes
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
    localparam logic [31:0] ALPHA_MASK   = 32'hFF00_0000;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] col_x;
        logic signed [15:0] row_y;
        logic [31:0]        colour_in;
    } req_item_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        in_range;
    } rsp_item_t;

    // classified job passed from front to back
    typedef struct packed {
        logic        is_write;
        logic        hit;
        logic [31:0] colour;
    } job_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } back_state_t;

    // one channel: d + floor((s - d) * a / 256)
    function automatic logic [7:0] blend_channel(input logic [7:0] s,
                                                 input logic [7:0] d,
                                                 input logic [7:0] a);
        logic [7:0]  diff;
        logic [16:0] prod;
        logic [7:0]  res;
        if (s >= d)
        begin
            diff = s - d;
            prod = 17'(diff) * 17'(a);
            res  = d + prod[15:8];
        end
        else
        begin
            // negative difference rounds toward minus infinity
            diff = d - s;
            prod = 17'(diff) * 17'(a) + 17'd255;
            res  = d - prod[15:8];
        end
        return res;
    endfunction

    // full pixel blend, source alpha counts as opaque inside the blend
    function automatic logic [31:0] blend_pixel(input logic [31:0] src,
                                                input logic [31:0] dst);
        logic [7:0]  a;
        logic [31:0] s2;
        logic [31:0] res;
        a   = src[31:24];
        s2  = src | ALPHA_MASK;
        res = dst;
        if (a == ALPHA_OPAQUE)
        begin
            res = src;
        end
        else if (a != ALPHA_CLEAR)
        begin
            for (int ch = 0; ch < 4; ch++)
            begin
                res[ch*8 +: 8] = blend_channel(s2[ch*8 +: 8], dst[ch*8 +: 8], a);
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/abps_queue.sv -----
// two-entry job queue between the front and the back
`timescale 1ns / 1ps

module abps_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_push;
    logic         do_pop;

    // status
    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/abps_front.sv -----
// front end: surface registers, bounds check and address of each request
`timescale 1ns / 1ps

module abps_front #(
    parameter int MAX_WIDTH  = abps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = abps_pkg::DEF_MAX_HEIGHT,
    parameter int AW         = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [abps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [abps_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             req_valid,
    input  abps_pkg::req_item_t              req,
    output logic                             req_stall,
    input  logic                             clearing,
    input  logic                             q_full,
    output logic                             push,
    output abps_pkg::job_t                   push_job,
    output logic [AW-1:0]                    push_addr
);

    localparam logic [15:0] X_LIMIT = 16'(MAX_WIDTH);
    localparam logic [15:0] Y_LIMIT = 16'(MAX_HEIGHT);

    logic [abps_pkg::CFG_W-1:0] width_reg;
    logic [abps_pkg::CFG_W-1:0] height_reg;
    logic [15:0]                col_u;
    logic [15:0]                row_u;
    logic                       x_ok;
    logic                       y_ok;
    logic [31:0]                addr_full;

    // surface size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= abps_pkg::SURFACE_RESET;
            height_reg <= abps_pkg::SURFACE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == abps_pkg::REG_SURFACE_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_index == abps_pkg::REG_SURFACE_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // bounds check against the register and the store limit
    always_comb
    begin
        col_u = req.col_x;
        row_u = req.row_y;
        x_ok  = !col_u[15] && (col_u < {7'b0, width_reg}) && (col_u < X_LIMIT);
        y_ok  = !row_u[15] && (row_u < {7'b0, height_reg}) && (row_u < Y_LIMIT);
    end

    // fixed row stride address
    assign addr_full = {16'b0, row_u} * 32'(MAX_WIDTH) + {16'b0, col_u};
    assign push_addr = addr_full[AW-1:0];

    // job classification and handshake
    assign req_stall         = clearing || q_full;
    assign push              = req_valid && !req_stall;
    assign push_job.is_write = (req.mode == abps_pkg::MODE_WRITE);
    assign push_job.hit      = x_ok && y_ok;
    assign push_job.colour   = req.colour_in;

endmodule

// ----- rtl/abps_back.sv -----
// back end: frame store, clearing sweep, read-modify-write and result register
`timescale 1ns / 1ps

module abps_back #(
    parameter int AW    = 16,
    parameter int DEPTH = 65536
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    output logic                 pop,
    input  abps_pkg::job_t       head_job,
    input  logic [AW-1:0]        head_addr,
    output logic                 clearing,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output abps_pkg::rsp_item_t  rsp
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    abps_pkg::back_state_t state_reg;
    abps_pkg::back_state_t state_next;

    logic [31:0]         mem [DEPTH];
    logic [31:0]         rdata_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [AW-1:0]       addr_reg;
    abps_pkg::job_t      job_reg;
    logic                rsp_valid_reg;
    abps_pkg::rsp_item_t rsp_reg;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [31:0]         mem_wdata;
    logic                mem_re;
    logic                load_rsp;
    abps_pkg::rsp_item_t rsp_value;
    logic [31:0]         blended;

    assign blended = abps_pkg::blend_pixel(job_reg.colour, rdata_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            abps_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = abps_pkg::ST_IDLE;
                end
            end
            abps_pkg::ST_IDLE:
            begin
                if (pop && head_job.hit)
                begin
                    state_next = abps_pkg::ST_READ;
                end
            end
            abps_pkg::ST_READ:
            begin
                state_next = abps_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = abps_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop       = 1'b0;
        clearing  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = blended;
        mem_re    = 1'b0;
        load_rsp  = 1'b0;
        rsp_value = '{pixel_out: 32'b0, in_range: 1'b0};
        unique case (state_reg)
            abps_pkg::ST_CLEAR:
            begin
                clearing  = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = 32'b0;
            end
            abps_pkg::ST_IDLE:
            begin
                pop = !q_empty && !rsp_valid_reg;
                if (pop)
                begin
                    // out of range answers at once, a hit reads the store
                    mem_re   = head_job.hit;
                    load_rsp = !head_job.hit;
                end
            end
            abps_pkg::ST_READ:
            begin
                mem_we   = job_reg.is_write;
                load_rsp = 1'b1;
                rsp_value.in_range  = 1'b1;
                rsp_value.pixel_out = job_reg.is_write ? blended : rdata_reg;
            end
            default:
            begin
                clearing = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= abps_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == abps_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // job and result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg  <= head_job;
            addr_reg <= head_addr;
        end
        if (load_rsp)
        begin
            rsp_reg <= rsp_value;
        end
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[head_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/alpha_blend_pixel_store_core.sv -----
// top level of the alpha blend pixel store
//
//  channel  | valid      | stall      | payload
//  request  | req_valid  | req_stall  | req (mode, col_x, row_y, colour_in)
//  response | rsp_valid  | rsp_stall  | rsp (pixel_out, in_range)
//  config   | cfg_we     | none       | cfg_index, cfg_data
//
// an in-range item passes the back end as pop and read, blend and write back,
// then result transfer; an out-of-range item as pop, then result transfer. no
// pop while a result waits, so the back end takes no new item until the last
// result has transferred. after reset all MAX_WIDTH * MAX_HEIGHT entries are
// swept to zero with req_stall high; configuration writes are taken meanwhile.
// a two-entry queue lets requests transfer while a result waits on rsp_stall.
`timescale 1ns / 1ps

module alpha_blend_pixel_store_core #(
    parameter int MAX_WIDTH  = abps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = abps_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [abps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [abps_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  abps_pkg::req_item_t              req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output abps_pkg::rsp_item_t              rsp
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int JW    = $bits(abps_pkg::job_t) + AW;

    logic           clearing;
    logic           q_full;
    logic           q_empty;
    logic           push;
    logic           pop;
    abps_pkg::job_t push_job;
    logic [AW-1:0]  push_addr;
    abps_pkg::job_t head_job;
    logic [AW-1:0]  head_addr;
    logic [JW-1:0]  push_data;
    logic [JW-1:0]  head_data;

    // request classification
    abps_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .clearing  (clearing),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job),
        .push_addr (push_addr)
    );

    // job queue
    assign push_data = {push_addr, push_job};
    assign head_addr = head_data[JW-1 -: AW];
    assign head_job  = head_data[$bits(abps_pkg::job_t)-1:0];

    abps_queue #(
        .W (JW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (head_data),
        .empty     (q_empty)
    );

    // store access and blending
    abps_back #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .pop       (pop),
        .head_job  (head_job),
        .head_addr (head_addr),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ----- rtl/abps_checker.sv -----
// port checker for the alpha blend pixel store, bound to the top level
`timescale 1ns / 1ps
`include "alpha_blend_pixel_store_core_assert.svh"

module abps_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input abps_pkg::rsp_item_t rsp
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       req_xfer;
    logic       rsp_xfer;

    // items accepted but not yet delivered
    assign req_xfer     = req_valid && !req_stall;
    assign rsp_xfer     = rsp_valid && !rsp_stall;
    assign pending_next = pending_reg + 3'(req_xfer) - 3'(rsp_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `ABPS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")
    `ABPS_ASSERT_IMPLY(a_miss_zero, clk, rst_n, rsp_valid && !rsp.in_range, rsp.pixel_out == 32'b0, "out of range response carries a pixel")
    `ABPS_ASSERT_IMPLY(a_no_phantom, clk, rst_n, rsp_valid, pending_reg != 3'd0, "response without an accepted request")
    `ABPS_ASSERT_IMPLY(a_bounded, clk, rst_n, 1'b1, pending_reg <= 3'd4, "more requests in flight than the design holds")

endmodule

bind alpha_blend_pixel_store_core abps_checker u_checker (.*);

// ----- sim/tb_alpha_blend_pixel_store_core.sv -----
// self-checking testbench for the alpha blend pixel store core
`timescale 1ns / 1ps

module tb_alpha_blend_pixel_store_core;

    // register indexes with no register behind them
    localparam logic [abps_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [abps_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int STORE_COLS      = abps_pkg::DEF_MAX_WIDTH;
    localparam int STORE_ROWS      = abps_pkg::DEF_MAX_HEIGHT;
    localparam int PRESSURE_AT     = 150;
    localparam int PRESSURE_CYCLES = 250;
    localparam int NUM_PHASES      = 12;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [abps_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [abps_pkg::CFG_W-1:0]       cfg_data;
    logic                             req_valid;
    logic                             req_stall;
    abps_pkg::req_item_t              req;
    logic                             rsp_valid;
    logic                             rsp_stall;
    abps_pkg::rsp_item_t              rsp;

    // frame store mirror, surface registers and expected responses
    class pixel_scoreboard;
        bit [31:0]           frame [STORE_COLS*STORE_ROWS];
        int unsigned         width_reg;
        int unsigned         height_reg;
        abps_pkg::rsp_item_t predicted_pixels[$];
        int                  n_checked;
        int                  n_errors;
        int                  n_read_hit;
        int                  n_write_hit;
        int                  n_miss;

        function new();
            width_reg   = abps_pkg::SURFACE_RESET;
            height_reg  = abps_pkg::SURFACE_RESET;
            n_checked   = 0;
            n_errors    = 0;
            n_read_hit  = 0;
            n_write_hit = 0;
            n_miss      = 0;
        endfunction

        function void set_reg(logic [abps_pkg::CFG_INDEX_W-1:0] idx,
                              logic [abps_pkg::CFG_W-1:0] data);
            if (idx == abps_pkg::REG_SURFACE_WIDTH)
                width_reg = data;
            else if (idx == abps_pkg::REG_SURFACE_HEIGHT)
                height_reg = data;
        endfunction

        // oversized registers clamp to the store size
        function int eff_width();
            return (width_reg > STORE_COLS) ? STORE_COLS : int'(width_reg);
        endfunction

        function int eff_height();
            return (height_reg > STORE_ROWS) ? STORE_ROWS : int'(height_reg);
        endfunction

        // d + floor((s - d) * a / 256), arithmetic shift gives the floor
        function bit [7:0] mix_channel(bit [7:0] s, bit [7:0] d, bit [7:0] a);
            int delta;
            delta = (int'(s) - int'(d)) * int'(a);
            return 8'(int'(d) + (delta >>> 8));
        endfunction

        function bit [31:0] mix_pixel(bit [31:0] src, bit [31:0] dst);
            bit [7:0]  a;
            bit [31:0] s_opaque;
            bit [31:0] mixed;
            a = src[31:24];
            if (a == abps_pkg::ALPHA_OPAQUE)
                return src;
            if (a == abps_pkg::ALPHA_CLEAR)
                return dst;
            s_opaque = src | abps_pkg::ALPHA_MASK;
            for (int ch = 0; ch < 4; ch++)
                mixed[ch*8 +: 8] = mix_channel(s_opaque[ch*8 +: 8], dst[ch*8 +: 8], a);
            return mixed;
        endfunction

        // accepted request: update the mirror and queue the response
        function void note_request(abps_pkg::req_item_t r);
            int                  xi;
            int                  yi;
            int                  addr;
            abps_pkg::rsp_item_t p;
            xi = r.col_x;
            yi = r.row_y;
            p  = '0;
            if (xi >= 0 && yi >= 0 && xi < eff_width() && yi < eff_height())
            begin
                addr       = yi * STORE_COLS + xi;
                p.in_range = 1'b1;
                if (r.mode == abps_pkg::MODE_WRITE)
                begin
                    frame[addr] = mix_pixel(r.colour_in, frame[addr]);
                    n_write_hit++;
                end
                else
                begin
                    n_read_hit++;
                end
                p.pixel_out = frame[addr];
            end
            else
            begin
                n_miss++;
            end
            predicted_pixels.push_back(p);
        endfunction

        // accepted response: compare with the oldest prediction
        function void check_response(abps_pkg::rsp_item_t r);
            abps_pkg::rsp_item_t e;
            n_checked++;
            if (predicted_pixels.size() == 0)
            begin
                $display("%0t: unexpected response pixel_out %h in_range %b",
                         $time, r.pixel_out, r.in_range);
                n_errors++;
                return;
            end
            e = predicted_pixels.pop_front();
            if (r.pixel_out !== e.pixel_out)
            begin
                $display("%0t: pixel_out mismatch expected %h actual %h",
                         $time, e.pixel_out, r.pixel_out);
                n_errors++;
            end
            if (r.in_range !== e.in_range)
            begin
                $display("%0t: in_range mismatch expected %b actual %b",
                         $time, e.in_range, r.in_range);
                n_errors++;
            end
        endfunction
    endclass

    pixel_scoreboard sb = new();
    int              pressure_done = 0;

    alpha_blend_pixel_store_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // overall limit
    initial
    begin
        #20_000_000;
        $display("tb_alpha_blend_pixel_store_core: done, errors");
        $finish;
    end

    function automatic abps_pkg::req_item_t make_req(logic mode, int x, int y,
                                                     logic [31:0] colour);
        abps_pkg::req_item_t r;
        r.mode      = mode;
        r.col_x     = 16'(x);
        r.row_y     = 16'(y);
        r.colour_in = colour;
        return r;
    endfunction

    // coordinates around the surface border
    function automatic int edge_coord(int lim);
        case ($urandom_range(0, 4))
            0:       return lim - 1;
            1:       return lim;
            2:       return lim + 1;
            3:       return -1;
            default: return 0;
        endcase
    endfunction

    // mostly in range, often in a small corner so reads find earlier writes
    function automatic abps_pkg::req_item_t rand_request(int w, int h);
        abps_pkg::req_item_t r;
        int                  pick;
        int                  span_x;
        int                  span_y;
        logic [7:0]          a;
        r.mode = 1'($urandom_range(0, 1));
        pick   = $urandom_range(0, 99);
        if (pick < 70 && w > 0 && h > 0)
        begin
            span_x  = ($urandom_range(0, 1) && w > 8) ? 8 : w;
            span_y  = ($urandom_range(0, 1) && h > 8) ? 8 : h;
            r.col_x = 16'($urandom_range(0, span_x - 1));
            r.row_y = 16'($urandom_range(0, span_y - 1));
        end
        else if (pick < 88)
        begin
            r.col_x = 16'(edge_coord(w));
            r.row_y = 16'(edge_coord(h));
        end
        else
        begin
            r.col_x = 16'($urandom);
            r.row_y = 16'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 15)
            a = abps_pkg::ALPHA_CLEAR;
        else if (pick < 30)
            a = abps_pkg::ALPHA_OPAQUE;
        else
            a = 8'($urandom);
        r.colour_in = {a, 24'($urandom)};
        return r;
    endfunction

    function automatic int pick_gap(bit burst);
        int pick;
        pick = $urandom_range(0, 99);
        if (burst || pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // one request transfer, called at a falling edge, returns at a falling edge
    task automatic send_item(abps_pkg::req_item_t it, int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(it);
        @(negedge clk);
    endtask

    // stop offering and wait until every response has come back
    task automatic drain_responses();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.predicted_pixels.size() != 0);
        @(negedge clk);
    endtask

    // surface registers, optionally poking the unused indexes as well
    task automatic set_surface(int w, int h, bit spare);
        cfg_we    <= 1'b1;
        cfg_index <= abps_pkg::REG_SURFACE_WIDTH;
        cfg_data  <= abps_pkg::CFG_W'(w);
        sb.set_reg(abps_pkg::REG_SURFACE_WIDTH, abps_pkg::CFG_W'(w));
        @(negedge clk);
        cfg_index <= abps_pkg::REG_SURFACE_HEIGHT;
        cfg_data  <= abps_pkg::CFG_W'(h);
        sb.set_reg(abps_pkg::REG_SURFACE_HEIGHT, abps_pkg::CFG_W'(h));
        @(negedge clk);
        if (spare)
        begin
            cfg_index <= REG_SPARE_2;
            cfg_data  <= abps_pkg::CFG_W'($urandom);
            @(negedge clk);
            cfg_index <= REG_SPARE_3;
            cfg_data  <= abps_pkg::CFG_W'($urandom);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // response checking at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
    end

    // receiver stall pattern with one long hold-off
    initial
    begin
        int free_left;
        int hold_left;
        int pick;
        free_left = 0;
        hold_left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!pressure_done && sb.n_checked >= PRESSURE_AT)
            begin
                pressure_done = 1;
                free_left     = 0;
                hold_left     = PRESSURE_CYCLES;
            end
            if (free_left == 0 && hold_left == 0)
            begin
                pick      = $urandom_range(0, 99);
                free_left = (pick < 10) ? $urandom_range(40, 80) : $urandom_range(1, 8);
                pick      = $urandom_range(0, 99);
                if (pick < 60)
                    hold_left = 0;
                else if (pick < 90)
                    hold_left = $urandom_range(1, 3);
                else if (pick < 98)
                    hold_left = $urandom_range(4, 12);
                else
                    hold_left = $urandom_range(20, 40);
            end
            if (free_left > 0)
            begin
                rsp_stall <= 1'b0;
                free_left--;
            end
            else
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
        end
    end

    // stimulus
    initial
    begin
        int phase_w [NUM_PHASES];
        int phase_h [NUM_PHASES];
        int w;
        int h;
        int n_items;
        bit burst;

        phase_w = '{256, 1, 0, 9, 511, 17, 256, 1, 257, 0, 8, 256};
        phase_h = '{256, 1, 7, 0, 300, 9, 1, 256, 511, 0, 8, 256};

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = abps_pkg::REG_SURFACE_WIDTH;
        cfg_data  = '0;
        req_valid = 1'b0;
        req       = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // directed: cleared store, opaque, clear and partial alpha, hazards, borders
        send_item(make_req(abps_pkg::MODE_READ,  0, 0, 32'h0), 0);
        send_item(make_req(abps_pkg::MODE_WRITE, 0, 0, 32'hFF12_3456), 0);
        send_item(make_req(abps_pkg::MODE_READ,  0, 0, 32'h0), 0);
        send_item(make_req(abps_pkg::MODE_WRITE, 0, 0, 32'h00AB_CDEF), 0);
        send_item(make_req(abps_pkg::MODE_WRITE, 0, 0, 32'h80FF_00FF), 0);
        send_item(make_req(abps_pkg::MODE_READ,  0, 0, 32'h0), 0);
        send_item(make_req(abps_pkg::MODE_WRITE, 255, 255, 32'h01FF_FFFF), 0);
        send_item(make_req(abps_pkg::MODE_WRITE, 255, 255, 32'hFE00_0000), 0);
        send_item(make_req(abps_pkg::MODE_READ,  255, 255, 32'h0), 0);
        send_item(make_req(abps_pkg::MODE_WRITE, 1, 0, 32'h40A0_B0C0), 0);
        send_item(make_req(abps_pkg::MODE_WRITE, 1, 0, 32'hC010_2030), 0);
        send_item(make_req(abps_pkg::MODE_READ,  1, 0, 32'h0), 0);
        send_item(make_req(abps_pkg::MODE_READ,  256, 0, 32'h0), 0);
        send_item(make_req(abps_pkg::MODE_READ,  0, 256, 32'h0), 0);
        send_item(make_req(abps_pkg::MODE_READ,  -1, 0, 32'h0), 0);
        send_item(make_req(abps_pkg::MODE_READ,  0, -1, 32'h0), 0);
        send_item(make_req(abps_pkg::MODE_WRITE, -32768, 32767, 32'hFFFF_FFFF), 0);
        send_item(make_req(abps_pkg::MODE_WRITE, 32767, -32768, 32'hFFFF_FFFF), 0);
        send_item(make_req(abps_pkg::MODE_WRITE, 256, 255, 32'hFF00_FF00), 1);
        send_item(make_req(abps_pkg::MODE_READ,  255, 256, 32'h0), 0);
        send_item(make_req(abps_pkg::MODE_WRITE, 0, 255, 32'h7F7F_7F7F), 2);
        send_item(make_req(abps_pkg::MODE_READ,  0, 255, 32'h0), 0);
        send_item(make_req(abps_pkg::MODE_READ,  0, 0, 32'h0), 0);

        // random phases over a range of surface settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_responses();
            w = phase_w[p];
            h = phase_h[p];
            if (p == 9)
            begin
                w = $urandom_range(1, 256);
                h = $urandom_range(1, 256);
            end
            set_surface(w, h, (p % 4) == 3);
            n_items = (p == 0) ? 600 : 120;
            burst   = (p % 4) == 2;
            repeat (n_items)
                send_item(rand_request(sb.eff_width(), sb.eff_height()), pick_gap(burst));
        end

        drain_responses();
        repeat (20) @(posedge clk);

        $display("covered %0d in-range reads, %0d in-range writes, %0d out-of-range requests",
                 sb.n_read_hit, sb.n_write_hit, sb.n_miss);
        $display("over %0d surface settings, %0d responses checked, one %0d-cycle hold-off",
                 NUM_PHASES + 1, sb.n_checked, PRESSURE_CYCLES);
        if (sb.n_errors == 0 && sb.predicted_pixels.size() == 0)
            $display("tb_alpha_blend_pixel_store_core: done, clean");
        else
            $display("tb_alpha_blend_pixel_store_core: done, errors");
        $finish;
    end

endmodule
